[rtl/iurv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iurv_pkg
// Shared types, constants and the one's-complement fold for the IPv4/UDP
// receive validator.
// ----------------------------------------------------------------------------
package iurv_pkg;

    // verdict codes, checked in this order
    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_BAD_HDR    = 3'd1,
        ERR_TRUNC_HDR  = 3'd2,
        ERR_HDR_CSUM   = 3'd3,
        ERR_TRUNC_PKT  = 3'd4,
        ERR_PROTO      = 3'd5,
        ERR_TRUNC_UDP  = 3'd6,
        ERR_UDP_CSUM   = 3'd7
    } t_err_code;

    // widest byte count the summary can carry
    localparam int SUM_COUNT_WIDTH = 16;

    // header byte positions of interest
    localparam int POS_VER_IHL   = 0;
    localparam int POS_TLEN_HI   = 2;
    localparam int POS_TLEN_LO   = 3;
    localparam int POS_PROTO     = 9;
    localparam int POS_ADDR_LO   = 12;
    localparam int POS_ADDR_HI   = 18;
    localparam int UDP_LEN_OFS   = 4;

    localparam logic [3:0]  IP_VERSION_4  = 4'd4;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
    localparam logic [6:0]  UDP_HDR_BYTES = 7'd8;
    localparam logic [15:0] SUM_GOOD      = 16'hffff;

    // per-packet summary handed from the accumulator to the verdict stage
    typedef struct packed {
        logic [3:0]                 version;
        logic [3:0]                 header_words;
        logic [SUM_COUNT_WIDTH-1:0] byte_count;
        logic [15:0]                total_length;
        logic [7:0]                 protocol;
        logic [15:0]                ip_sum;
        logic [15:0]                udp_sum;
    } t_pkt_summary;

    // fold a sum of up to five 16-bit terms back to 16 bits, end-around carry
    function automatic logic [15:0] f_ones_fold(input logic [18:0] s);
        logic [16:0] t;
        begin
            t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
            return t[15:0] + {15'd0, t[16]};
        end
    endfunction

endpackage

[rtl/iurv_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iurv_accum
// Input register, per-byte header capture and checksum accumulation, and the
// per-packet summary register loaded on the marked final byte.
// ----------------------------------------------------------------------------
module iurv_accum #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_in_last,
    output logic                  o_sum_valid,
    input  logic                  i_sum_ready,
    output iurv_pkg::t_pkt_summary o_sum
);
    import iurv_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // packet state
    logic [COUNT_WIDTH-1:0] r_byte_count, n_byte_count;
    logic [3:0]             r_version, n_version;
    logic [3:0]             r_header_words, n_header_words;
    logic [15:0]            r_total_length, n_total_length;
    logic [7:0]             r_protocol, n_protocol;
    logic [15:0]            r_ip_sum, n_ip_sum;
    logic [15:0]            r_udp_sum, n_udp_sum;
    logic [7:0]             r_held, n_held;
    logic                   r_pending, n_pending;

    // summary register
    logic         r_sum_valid;
    t_pkt_summary r_sum;

    logic                   w_consume;
    logic                   w_sum_free;
    logic [COUNT_WIDTH-1:0] w_pos;
    logic [COUNT_WIDTH-1:0] w_wpos;
    logic                   w_take;
    logic [15:0]            w_word;
    logic [5:0]             w_hdr_bytes;
    logic [COUNT_WIDTH-1:0] w_hdr_pos;
    logic [COUNT_WIDTH-1:0] w_len_pos;
    logic                   w_in_hdr;
    logic                   w_in_addr;
    logic                   w_after_hdr;
    logic                   w_is_len;
    logic [15:0]            w_ip_add;
    logic [15:0]            w_proto_add;
    logic [15:0]            w_addr_add;
    logic [15:0]            w_body_add;
    logic [15:0]            w_len_add;

    // handshake: a final byte waits for room in the summary register
    assign w_sum_free = !r_sum_valid || i_sum_ready;
    assign w_consume  = r_in_valid && (!r_in_last || w_sum_free);
    assign o_in_ready = !r_in_valid || w_consume;

    // header field capture
    always_comb begin
        w_pos          = r_byte_count;
        n_version      = r_version;
        n_header_words = r_header_words;
        n_total_length = r_total_length;
        n_protocol     = r_protocol;
        if (w_pos == COUNT_WIDTH'(POS_VER_IHL)) begin
            n_version      = r_in_byte[7:4];
            n_header_words = r_in_byte[3:0];
        end
        if (w_pos == COUNT_WIDTH'(POS_TLEN_HI)) begin
            n_total_length = {r_in_byte, r_total_length[7:0]};
        end
        if (w_pos == COUNT_WIDTH'(POS_TLEN_LO)) begin
            n_total_length = {r_total_length[15:8], r_in_byte};
        end
        if (w_pos == COUNT_WIDTH'(POS_PROTO)) begin
            n_protocol = r_in_byte;
        end
    end

    // word pairing: a word completes on the second byte, or padded on a final odd byte
    always_comb begin
        w_take    = r_pending || r_in_last;
        w_wpos    = r_pending ? (w_pos - COUNT_WIDTH'(1)) : w_pos;
        w_word    = r_pending ? {r_held, r_in_byte} : {r_in_byte, 8'h00};
        n_pending = !r_pending;
        n_held    = r_pending ? r_held : r_in_byte;
        n_byte_count = (r_byte_count < COUNT_MAX) ? (r_byte_count + COUNT_WIDTH'(1))
                                                  : r_byte_count;
    end

    // route the completed word into the header and udp sums
    always_comb begin
        w_hdr_bytes = {n_header_words, 2'b00};
        w_hdr_pos   = COUNT_WIDTH'(w_hdr_bytes);
        w_len_pos   = COUNT_WIDTH'({1'b0, w_hdr_bytes} + 7'(UDP_LEN_OFS));
        w_in_hdr    = w_take && (w_wpos < w_hdr_pos);
        w_in_addr   = w_take && (w_wpos >= COUNT_WIDTH'(POS_ADDR_LO))
                             && (w_wpos <= COUNT_WIDTH'(POS_ADDR_HI));
        w_after_hdr = w_take && (w_wpos >= w_hdr_pos);
        w_is_len    = w_after_hdr && (w_wpos == w_len_pos);

        w_ip_add    = w_in_hdr ? w_word : 16'd0;
        w_proto_add = (w_pos == COUNT_WIDTH'(POS_PROTO)) ? {8'd0, r_in_byte} : 16'd0;
        w_addr_add  = w_in_addr ? w_word : 16'd0;
        w_body_add  = w_after_hdr ? w_word : 16'd0;
        w_len_add   = w_is_len ? w_word : 16'd0;

        n_ip_sum  = f_ones_fold({3'd0, r_ip_sum} + {3'd0, w_ip_add});
        n_udp_sum = f_ones_fold({3'd0, r_udp_sum} + {3'd0, w_proto_add}
                              + {3'd0, w_addr_add} + {3'd0, w_body_add}
                              + {3'd0, w_len_add});
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    // packet state, cleared when the final byte of each packet is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_consume && r_in_last)) begin
            r_byte_count   <= '0;
            r_version      <= '0;
            r_header_words <= '0;
            r_total_length <= '0;
            r_protocol     <= '0;
            r_ip_sum       <= '0;
            r_udp_sum      <= '0;
            r_held         <= '0;
            r_pending      <= 1'b0;
        end else if (w_consume) begin
            r_byte_count   <= n_byte_count;
            r_version      <= n_version;
            r_header_words <= n_header_words;
            r_total_length <= n_total_length;
            r_protocol     <= n_protocol;
            r_ip_sum       <= n_ip_sum;
            r_udp_sum      <= n_udp_sum;
            r_held         <= n_held;
            r_pending      <= n_pending;
        end
    end

    // summary register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (w_sum_free) begin
            r_sum_valid <= w_consume && r_in_last;
        end
        if (w_consume && r_in_last) begin
            r_sum.version      <= n_version;
            r_sum.header_words <= n_header_words;
            r_sum.byte_count   <= SUM_COUNT_WIDTH'(n_byte_count);
            r_sum.total_length <= n_total_length;
            r_sum.protocol     <= n_protocol;
            r_sum.ip_sum       <= n_ip_sum;
            r_sum.udp_sum      <= n_udp_sum;
        end
    end

    assign o_sum_valid = r_sum_valid;
    assign o_sum       = r_sum;

endmodule

[rtl/iurv_verdict.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iurv_verdict
// Turns a packet summary into the error code and payload placement, held in
// the result register until the downstream side takes it.
// ----------------------------------------------------------------------------
module iurv_verdict (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_sum_valid,
    output logic                   o_sum_ready,
    input  iurv_pkg::t_pkt_summary i_sum,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output iurv_pkg::t_err_code    o_error_code,
    output logic [15:0]            o_payload_length,
    output logic [6:0]             o_payload_offset
);
    import iurv_pkg::*;

    logic        r_res_valid;
    t_err_code   r_code, n_code;
    logic [15:0] r_plen, n_plen;
    logic [6:0]  r_poff, n_poff;

    logic [5:0]  w_hdr;
    logic [6:0]  w_body_ofs;
    logic [15:0] w_hdr16;
    logic [15:0] w_ofs16;

    assign o_sum_ready = !r_res_valid || i_res_ready;

    // checks in priority order
    always_comb begin
        w_hdr      = {i_sum.header_words, 2'b00};
        w_body_ofs = {1'b0, w_hdr} + UDP_HDR_BYTES;
        w_hdr16    = 16'(w_hdr);
        w_ofs16    = 16'(w_body_ofs);
        if (i_sum.version != IP_VERSION_4 || w_hdr < MIN_HDR_BYTES) begin
            n_code = ERR_BAD_HDR;
        end else if (i_sum.byte_count < w_hdr16) begin
            n_code = ERR_TRUNC_HDR;
        end else if (i_sum.ip_sum != SUM_GOOD) begin
            n_code = ERR_HDR_CSUM;
        end else if (i_sum.byte_count < i_sum.total_length) begin
            n_code = ERR_TRUNC_PKT;
        end else if (i_sum.protocol != PROTO_UDP) begin
            n_code = ERR_PROTO;
        end else if (i_sum.byte_count < w_ofs16) begin
            n_code = ERR_TRUNC_UDP;
        end else if (i_sum.udp_sum != SUM_GOOD) begin
            n_code = ERR_UDP_CSUM;
        end else begin
            n_code = ERR_OK;
        end
    end

    // payload placement, zero on any error
    always_comb begin
        n_plen = 16'd0;
        n_poff = 7'd0;
        if (n_code == ERR_OK) begin
            n_poff = w_body_ofs;
            n_plen = (i_sum.total_length > w_ofs16) ? (i_sum.total_length - w_ofs16)
                                                    : 16'd0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_sum_ready) begin
            r_res_valid <= i_sum_valid;
        end
        if (o_sum_ready && i_sum_valid) begin
            r_code <= n_code;
            r_plen <= n_plen;
            r_poff <= n_poff;
        end
    end

    assign o_res_valid      = r_res_valid;
    assign o_error_code     = r_code;
    assign o_payload_length = r_plen;
    assign o_payload_offset = r_poff;

endmodule

[rtl/ipv4_udp_rx_validator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_udp_rx_validator_unit
// IPv4/UDP receive validator: header, length and checksum checks per packet.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle on the slave stream, starting at the first
// IP header byte, with tlast on the final byte. After the final byte it gives
// one verdict transfer on the master stream: the first failing check (bad
// version or header length, truncated header, header checksum, truncated
// packet, not UDP, truncated UDP header, UDP checksum) or zero, with payload
// length and offset on success. Bytes are taken back to back at one per
// cycle; only a final byte can wait, and only while both the summary and the
// result registers are full and the master side is not ready. After the
// edge that takes the final byte, the verdict passes the input register,
// the summary register and the result register before it can transfer.
// The byte counter is COUNT_WIDTH bits and saturates, so longer packets
// report as truncated when the total length exceeds its range.
// ----------------------------------------------------------------------------
module ipv4_udp_rx_validator_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] packet_byte
    input  logic        i_s_axis_tlast,   // last_byte
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [2:0] error_code, [18:3] payload_length,
                                          // [25:19] payload_offset, [31:26] zero
);
    import iurv_pkg::*;

    logic         w_sum_valid;
    logic         w_sum_ready;
    t_pkt_summary w_sum;
    t_err_code    w_code;
    logic [15:0]  w_plen;
    logic [6:0]   w_poff;

    // byte accumulation and per-packet summary
    iurv_accum #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_byte   (i_s_axis_tdata),
        .i_in_last   (i_s_axis_tlast),
        .o_sum_valid (w_sum_valid),
        .i_sum_ready (w_sum_ready),
        .o_sum       (w_sum)
    );

    // verdict and result register
    iurv_verdict u_verdict (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sum_valid      (w_sum_valid),
        .o_sum_ready      (w_sum_ready),
        .i_sum            (w_sum),
        .o_res_valid      (o_m_axis_tvalid),
        .i_res_ready      (i_m_axis_tready),
        .o_error_code     (w_code),
        .o_payload_length (w_plen),
        .o_payload_offset (w_poff)
    );

    // pack result fields, lowest first
    assign o_m_axis_tdata = {6'd0, w_poff, w_plen, w_code};

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv4/UDP receive validator.
// ----------------------------------------------------------------------------
// Streams IPv4 packets into the slave side one byte per transfer and checks
// every verdict on the master side against a cycle-free predictor that
// tracks header fields and both one's-complement sums byte by byte. A short
// table of runt packets comes first, with the verdict written in where it is
// obvious. Random packets follow: many well-formed IPv4/UDP packets with
// correct checksums and random content, plus broken ones (bad version or
// header length, cut short, wrong protocol, total length too big, a flipped
// bit, a zeroed UDP checksum) and plain noise. Both sides stall at random
// except near the end of the run.
// ----------------------------------------------------------------------------
module tb_top;
    import iurv_pkg::*;

    localparam int COUNT_WIDTH   = 16;
    localparam int COUNT_MAX     = (1 << COUNT_WIDTH) - 1;
    localparam int RANDOM_BYTES  = 1450;
    localparam int CALM_AFTER    = 1200;
    localparam int PAUSE_AT      = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int N_DIRECTED    = 15;

    typedef logic [7:0] t_byte;

    // one verdict as carried on the master stream
    typedef struct packed {
        t_err_code   code;
        logic [15:0] plen;
        logic [6:0]  poff;
    } t_verdict;

    // one row of the directed table
    typedef struct packed {
        t_byte       data;
        logic        last;
        logic        pinned;
        t_err_code   code;
        logic [15:0] plen;
        logic [6:0]  poff;
    } t_row;

    // shapes of random packet
    typedef enum int {
        PK_GOOD       = 0,
        PK_SHORT_TLEN = 1,
        PK_TAIL       = 2,
        PK_BAD_VER    = 3,
        PK_BAD_IHL    = 4,
        PK_TRUNC      = 5,
        PK_TLEN_BIG   = 6,
        PK_PROTO      = 7,
        PK_CORRUPT    = 8,
        PK_ZERO_UDP   = 9,
        PK_NOISE      = 10
    } t_shape;

    // runt packets: every verdict here follows from the first bytes alone
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b1, ERR_BAD_HDR,   16'd0, 7'd0},
        '{8'hff, 1'b1, 1'b1, ERR_BAD_HDR,   16'd0, 7'd0},
        '{8'h44, 1'b1, 1'b1, ERR_BAD_HDR,   16'd0, 7'd0},
        '{8'h40, 1'b1, 1'b1, ERR_BAD_HDR,   16'd0, 7'd0},
        '{8'h45, 1'b1, 1'b1, ERR_TRUNC_HDR, 16'd0, 7'd0},
        '{8'h4f, 1'b1, 1'b1, ERR_TRUNC_HDR, 16'd0, 7'd0},
        '{8'h45, 1'b0, 1'b0, ERR_OK,        16'd0, 7'd0},
        '{8'h00, 1'b0, 1'b0, ERR_OK,        16'd0, 7'd0},
        '{8'hff, 1'b0, 1'b0, ERR_OK,        16'd0, 7'd0},
        '{8'hff, 1'b1, 1'b1, ERR_TRUNC_HDR, 16'd0, 7'd0},
        '{8'h54, 1'b1, 1'b1, ERR_BAD_HDR,   16'd0, 7'd0},
        '{8'h46, 1'b0, 1'b0, ERR_OK,        16'd0, 7'd0},
        '{8'h80, 1'b0, 1'b0, ERR_OK,        16'd0, 7'd0},
        '{8'h7f, 1'b0, 1'b0, ERR_OK,        16'd0, 7'd0},
        '{8'h01, 1'b1, 1'b1, ERR_TRUNC_HDR, 16'd0, 7'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    t_byte       s_data = 8'h00;
    logic        s_last = 1'b0;
    logic        s_pinned = 1'b0;
    t_verdict    s_pin_verdict = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_data;

    t_verdict    verdicts_due[$];
    t_byte       pkt[$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          src_gaps = 1'b1;

    // predictor state, cleared after every verdict
    int          seen_count = 0;
    logic [3:0]  seen_ver = '0;
    logic [3:0]  seen_ihl = '0;
    logic [15:0] seen_tlen = '0;
    logic [7:0]  seen_proto = '0;
    logic [15:0] hdr_acc = '0;
    logic [15:0] udp_acc = '0;
    t_byte       pend_hi = '0;
    bit          pend_flag = 1'b0;

    ipv4_udp_rx_validator_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // 16-bit one's-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // route one word to the header sum, the udp sum, or both
    function automatic void fold_word(input int at, input logic [15:0] w);
        int hdr_bytes;
        hdr_bytes = int'(seen_ihl) * 4;
        if (at < hdr_bytes)
            hdr_acc = oc_add(hdr_acc, w);
        if (at >= POS_ADDR_LO && at <= POS_ADDR_HI)
            udp_acc = oc_add(udp_acc, w);
        if (at >= hdr_bytes) begin
            udp_acc = oc_add(udp_acc, w);
            // udp length also counts once more as pseudo-header
            if (at == hdr_bytes + UDP_LEN_OFS)
                udp_acc = oc_add(udp_acc, w);
        end
    endfunction

    function automatic void clear_tracking();
        seen_count = 0;
        seen_ver   = '0;
        seen_ihl   = '0;
        seen_tlen  = '0;
        seen_proto = '0;
        hdr_acc    = '0;
        udp_acc    = '0;
        pend_hi    = '0;
        pend_flag  = 1'b0;
    endfunction

    // advance the predictor by one accepted byte; a verdict on the last one
    function automatic bit predict_verdict(input t_byte b, input logic last,
                                           output t_verdict v);
        int at;
        int hdr_bytes;
        int off;
        at = seen_count;
        v = '0;
        case (at)
            POS_VER_IHL: begin
                seen_ver = b[7:4];
                seen_ihl = b[3:0];
            end
            POS_TLEN_HI: seen_tlen[15:8] = b;
            POS_TLEN_LO: seen_tlen[7:0] = b;
            POS_PROTO: begin
                seen_proto = b;
                udp_acc = oc_add(udp_acc, {8'h00, b});
            end
            default: ;
        endcase
        // pair bytes into words by position parity
        if (pend_flag) begin
            fold_word(at - 1, {pend_hi, b});
            pend_flag = 1'b0;
        end else begin
            pend_hi = b;
            pend_flag = 1'b1;
        end
        if (seen_count < COUNT_MAX)
            seen_count++;
        if (!last)
            return 1'b0;
        // odd final byte padded with zero
        if (pend_flag)
            fold_word(at, {pend_hi, 8'h00});
        hdr_bytes = int'(seen_ihl) * 4;
        if (seen_ver != IP_VERSION_4 || hdr_bytes < int'(MIN_HDR_BYTES))
            v.code = ERR_BAD_HDR;
        else if (seen_count < hdr_bytes)
            v.code = ERR_TRUNC_HDR;
        else if (hdr_acc != SUM_GOOD)
            v.code = ERR_HDR_CSUM;
        else if (seen_count < int'(seen_tlen))
            v.code = ERR_TRUNC_PKT;
        else if (seen_proto != PROTO_UDP)
            v.code = ERR_PROTO;
        else if (seen_count - hdr_bytes < int'(UDP_HDR_BYTES))
            v.code = ERR_TRUNC_UDP;
        else if (udp_acc != SUM_GOOD)
            v.code = ERR_UDP_CSUM;
        else
            v.code = ERR_OK;
        if (v.code == ERR_OK) begin
            off = hdr_bytes + int'(UDP_HDR_BYTES);
            v.poff = 7'(off);
            v.plen = (int'(seen_tlen) > off) ? 16'(int'(seen_tlen) - off) : 16'd0;
        end
        clear_tracking();
        return 1'b1;
    endfunction

    // build one random packet into pkt
    task automatic build_packet();
        int          r;
        int          ihl;
        int          hdr;
        int          plen;
        int          n;
        int          i;
        int          idx;
        int          v;
        t_shape      shape;
        logic [15:0] tlen;
        logic [15:0] ulen;
        logic [15:0] s;
        t_byte       proto;
        pkt.delete();
        r = $urandom_range(0, 17);
        shape = (r < 8) ? PK_GOOD : t_shape'(r - 7);
        if (shape == PK_NOISE) begin
            repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
            return;
        end
        // mostly plain 20-byte headers, sometimes with options
        ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        hdr  = ihl * 4;
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
        n    = hdr + int'(UDP_HDR_BYTES) + plen;
        for (i = 0; i < n; i++)
            pkt.push_back(8'($urandom));
        if (shape == PK_TAIL)
            repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom));
        tlen = 16'(n);
        if (shape == PK_SHORT_TLEN)
            tlen = 16'($urandom_range(0, hdr + int'(UDP_HDR_BYTES)));
        if (shape == PK_TLEN_BIG)
            tlen = 16'(n + $urandom_range(1, 100));
        proto = PROTO_UDP;
        if (shape == PK_PROTO) begin
            v = $urandom_range(0, 254);
            if (v >= int'(PROTO_UDP))
                v++;
            proto = 8'(v);
        end
        ulen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(int'(UDP_HDR_BYTES) + plen);
        pkt[POS_VER_IHL] = {IP_VERSION_4, 4'(ihl)};
        pkt[POS_TLEN_HI] = tlen[15:8];
        pkt[POS_TLEN_LO] = tlen[7:0];
        pkt[POS_PROTO]   = proto;
        pkt[hdr + UDP_LEN_OFS]     = ulen[15:8];
        pkt[hdr + UDP_LEN_OFS + 1] = ulen[7:0];
        // header checksum
        pkt[10] = 8'h00;
        pkt[11] = 8'h00;
        s = '0;
        for (i = 0; i < hdr; i += 2)
            s = oc_add(s, {pkt[i], pkt[i + 1]});
        s = ~s;
        pkt[10] = s[15:8];
        pkt[11] = s[7:0];
        // udp checksum: pseudo-header plus every byte after the ip header
        pkt[hdr + 6] = 8'h00;
        pkt[hdr + 7] = 8'h00;
        s = oc_add({8'h00, proto}, ulen);
        for (i = POS_ADDR_LO; i <= POS_ADDR_HI; i += 2)
            s = oc_add(s, {pkt[i], pkt[i + 1]});
        for (i = hdr; i < pkt.size(); i += 2)
            s = oc_add(s, {pkt[i], (i + 1 < pkt.size()) ? pkt[i + 1] : 8'h00});
        s = ~s;
        pkt[hdr + 6] = s[15:8];
        pkt[hdr + 7] = s[7:0];
        // damage applied after the sums
        case (shape)
            PK_BAD_VER: begin
                v = $urandom_range(0, 14);
                if (v >= int'(IP_VERSION_4))
                    v++;
                pkt[POS_VER_IHL] = {4'(v), 4'(ihl)};
            end
            PK_BAD_IHL: pkt[POS_VER_IHL] = {IP_VERSION_4, 4'($urandom_range(0, 4))};
            PK_TRUNC: begin
                idx = $urandom_range(1, pkt.size() - 1);
                while (pkt.size() > idx)
                    void'(pkt.pop_back());
            end
            PK_CORRUPT: begin
                idx = $urandom_range(0, pkt.size() - 1);
                pkt[idx] = pkt[idx] ^ 8'(1 << $urandom_range(0, 7));
            end
            PK_ZERO_UDP: begin
                pkt[hdr + 6] = 8'h00;
                pkt[hdr + 7] = 8'h00;
            end
            default: ;
        endcase
    endtask

    // offer one byte and hold it until the transfer
    task automatic push_byte(input t_byte b, input logic last, input logic pinned,
                             input t_verdict pv);
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_valid       <= 1'b1;
        s_data        <= b;
        s_last        <= last;
        s_pinned      <= pinned;
        s_pin_verdict <= pv;
        do @(posedge clk); while (!s_ready);
    endtask

    // stop sending until every verdict due has arrived
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge clk); while (verdicts_due.size() != 0);
    endtask

    // stimulus
    initial begin
        int       i;
        int       bytes_sent;
        int       packets;
        t_verdict pv;
        bytes_sent = 0;
        packets = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed runts
        for (i = 0; i < N_DIRECTED; i++) begin
            pv.code = DIRECTED[i].code;
            pv.plen = DIRECTED[i].plen;
            pv.poff = DIRECTED[i].poff;
            push_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].pinned, pv);
        end
        drain();
        // random packets
        while (bytes_sent < RANDOM_BYTES) begin
            if (bytes_sent >= CALM_AFTER)
                calm = 1'b1;
            src_gaps = !calm && ($urandom_range(0, 2) != 0);
            build_packet();
            for (i = 0; i < pkt.size(); i++)
                push_byte(pkt[i], (i == pkt.size() - 1), 1'b0, '0);
            bytes_sent += pkt.size();
            packets++;
            if (packets == PAUSE_AT)
                drain();
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // result side back-pressure
    initial begin
        @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    end

    // check verdict transfers, then feed accepted bytes to the predictor
    always @(posedge clk) begin
        t_verdict got;
        t_verdict want;
        t_verdict pred;
        if (rst_n && m_valid && m_ready) begin
            got.code = t_err_code'(m_data[2:0]);
            got.plen = m_data[18:3];
            got.poff = m_data[25:19];
            if (verdicts_due.size() == 0) begin
                $error("unexpected verdict: error_code %0d payload_length %0d payload_offset %0d",
                       got.code, got.plen, got.poff);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                if (got.code != want.code) begin
                    $error("error_code: expected %0d, got %0d", want.code, got.code);
                    errors++;
                end
                if (got.plen != want.plen) begin
                    $error("payload_length: expected %0d, got %0d", want.plen, got.plen);
                    errors++;
                end
                if (got.poff != want.poff) begin
                    $error("payload_offset: expected %0d, got %0d", want.poff, got.poff);
                    errors++;
                end
            end
        end
        if (rst_n && s_valid && s_ready) begin
            if (predict_verdict(s_data, s_last, pred))
                verdicts_due.push_back(s_pinned ? s_pin_verdict : pred);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

[ipv4_udp_rx_validator_unit.f]
rtl/iurv_pkg.sv
rtl/iurv_accum.sv
rtl/iurv_verdict.sv
rtl/ipv4_udp_rx_validator_unit.sv
dv/tb_top.sv
